@@ hw/rtl/spbm_pkg.sv @@
`default_nettype none

package spbm_pkg;

    // Item kind carried in tuser
    typedef enum logic [1:0] {
        FUNC_NEXT    = 2'd0,
        FUNC_FIRST   = 2'd1,
        FUNC_NEW_SET = 2'd2,
        FUNC_APPEND  = 2'd3
    } func_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_ANGLE_START = 2'd0;
    localparam logic [1:0] CFG_ANGLE_STEP  = 2'd1;
    localparam logic [1:0] CFG_MAX_BOXES   = 2'd2;

    localparam logic [5:0]  MAX_BOXES_RESET = 6'd20;
    localparam logic [31:0] TWO_PI_Q29      = 32'd3373259426;
    localparam logic [30:0] Q30_ONE         = 31'h4000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOX,
        ST_MATH,
        ST_SCAN,
        ST_LOAD
    } state_t;

    // Micro-op kinds of the shared multiply sequence
    typedef enum logic [3:0] {
        UOP_ANGLE,
        UOP_RAD,
        UOP_SQ,
        UOP_DIVM,
        UOP_DIVC,
        UOP_MULP,
        UOP_SIN,
        UOP_SCX,
        UOP_SCY
    } uop_kind_t;

    // Constant divisors of the Taylor series
    typedef enum logic [2:0] {
        DIV_72,
        DIV_42,
        DIV_20,
        DIV_6,
        DIV_56,
        DIV_30,
        DIV_12,
        DIV_2
    } div_sel_t;

    typedef struct packed {
        uop_kind_t kind;
        div_sel_t  dsel;
    } uop_t;

    localparam logic [4:0] UOP_LAST = 5'd27;

    typedef struct packed {
        logic capture;
        logic box_wr;
        logic mul_en;
        logic wb_en;
        uop_t uop;
        logic scan_start;
        logic scan_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

    // Divisor value
    function automatic logic [6:0] div_value(div_sel_t d);
        logic [6:0] v;
        case (d)
            DIV_72:  v = 7'd72;
            DIV_42:  v = 7'd42;
            DIV_20:  v = 7'd20;
            DIV_6:   v = 7'd6;
            DIV_56:  v = 7'd56;
            DIV_30:  v = 7'd30;
            DIV_12:  v = 7'd12;
            DIV_2:   v = 7'd2;
            default: v = 7'd2;
        endcase
        return v;
    endfunction

    // floor(2^32 / divisor); quotient estimate is exact or one low
    function automatic logic [31:0] div_recip(div_sel_t d);
        logic [31:0] v;
        case (d)
            DIV_72:  v = 32'd59652323;
            DIV_42:  v = 32'd102261126;
            DIV_20:  v = 32'd214748364;
            DIV_6:   v = 32'd715827882;
            DIV_56:  v = 32'd76695844;
            DIV_30:  v = 32'd143165576;
            DIV_12:  v = 32'd357913941;
            DIV_2:   v = 32'd2147483648;
            default: v = 32'd2147483648;
        endcase
        return v;
    endfunction

    // Micro-program: angle, radians, square, sine series, cosine series, scaling
    function automatic uop_t uop_at(logic [4:0] step);
        uop_t u;
        case (step)
            5'd0:    u = '{UOP_ANGLE, DIV_72};
            5'd1:    u = '{UOP_RAD,   DIV_72};
            5'd2:    u = '{UOP_SQ,    DIV_72};
            5'd3:    u = '{UOP_DIVM,  DIV_72};
            5'd4:    u = '{UOP_DIVC,  DIV_72};
            5'd5:    u = '{UOP_MULP,  DIV_42};
            5'd6:    u = '{UOP_DIVM,  DIV_42};
            5'd7:    u = '{UOP_DIVC,  DIV_42};
            5'd8:    u = '{UOP_MULP,  DIV_20};
            5'd9:    u = '{UOP_DIVM,  DIV_20};
            5'd10:   u = '{UOP_DIVC,  DIV_20};
            5'd11:   u = '{UOP_MULP,  DIV_6};
            5'd12:   u = '{UOP_DIVM,  DIV_6};
            5'd13:   u = '{UOP_DIVC,  DIV_6};
            5'd14:   u = '{UOP_SIN,   DIV_56};
            5'd15:   u = '{UOP_DIVM,  DIV_56};
            5'd16:   u = '{UOP_DIVC,  DIV_56};
            5'd17:   u = '{UOP_MULP,  DIV_30};
            5'd18:   u = '{UOP_DIVM,  DIV_30};
            5'd19:   u = '{UOP_DIVC,  DIV_30};
            5'd20:   u = '{UOP_MULP,  DIV_12};
            5'd21:   u = '{UOP_DIVM,  DIV_12};
            5'd22:   u = '{UOP_DIVC,  DIV_12};
            5'd23:   u = '{UOP_MULP,  DIV_2};
            5'd24:   u = '{UOP_DIVM,  DIV_2};
            5'd25:   u = '{UOP_DIVC,  DIV_2};
            5'd26:   u = '{UOP_SCX,   DIV_2};
            5'd27:   u = '{UOP_SCY,   DIV_2};
            default: u = '{UOP_SCY,   DIV_2};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/spbm_ctrl.sv @@
`default_nettype none

module spbm_ctrl
    import spbm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_func,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       phase_reg, phase_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.uop        = uop_at(step_reg);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    phase_next  = 1'b0;
                    if (func_t'(in_func) inside {FUNC_NEW_SET, FUNC_APPEND})
                        state_next = ST_BOX;
                    else
                        state_next = ST_MATH;
                end
            end
            ST_BOX:
            begin
                cmd.box_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MATH:
            begin
                if (!phase_reg)
                begin
                    cmd.mul_en = 1'b1;
                    phase_next = 1'b1;
                end
                else
                begin
                    cmd.wb_en  = 1'b1;
                    phase_next = 1'b0;
                    if (step_reg == UOP_LAST)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                        step_next = step_reg + 5'd1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/spbm_dp.sv @@
`default_nettype none

module spbm_dp
    import spbm_pkg::*;
#(
    parameter int MAX_BOXES   = 32,
    parameter int MAX_SAMPLES = 4096
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ctrl_cmd_t    cmd,
    output dp_status_t        status,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic [167:0] in_data,
    input  wire logic [1:0]   in_func,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       out_data
);

    localparam int CNTW  = $clog2(MAX_BOXES + 1);
    localparam int IDXW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int LIMW  = (CNTW > 6) ? CNTW : 6;
    localparam int SIDXW = $clog2(MAX_SAMPLES);

    typedef struct packed {
        logic signed [17:0] lo_x;
        logic signed [17:0] hi_x;
        logic signed [17:0] lo_y;
        logic signed [17:0] hi_y;
    } box_t;

    // Configuration
    logic [15:0] angle_start_reg, angle_step_reg;
    logic [5:0]  max_boxes_reg;

    // Captured item
    func_t              func_reg;
    logic [16:0]        range_reg;
    logic               inval_reg;
    logic signed [17:0] cx_reg [4];
    logic signed [17:0] cy_reg [4];

    // Sequencing state
    logic [SIDXW-1:0] idx_reg, next_index_reg, idx_sel;
    logic [CNTW-1:0]  box_count_reg, box_base, rd_idx_reg;

    // Math registers
    logic [63:0]        prod_reg;
    logic [31:0]        op_a, op_b;
    logic [1:0]         k_reg;
    logic               tneg_reg;
    logic [13:0]        u_reg;
    logic [29:0]        x_reg, x2_reg, n_reg, q_reg;
    logic [30:0]        p_reg, s_reg;
    logic signed [17:0] px_reg, py_reg;

    // Scan and output
    box_t        box_mem [MAX_BOXES];
    box_t        rd_data_reg, wr_box;
    logic        rd_vld_reg, hit_reg, rd_issue;
    logic        out_vld_reg;
    logic [31:0] out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= '0;
            angle_step_reg  <= '0;
            max_boxes_reg   <= MAX_BOXES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ANGLE_START: angle_start_reg <= cfg_data;
                CFG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                CFG_MAX_BOXES:   max_boxes_reg   <= cfg_data[5:0];
                default:         ;
            endcase
        end
    end

    // Capture of the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func_t'(in_func);
            range_reg <= in_data[16:0];
            inval_reg <= in_data[17];
            for (int i = 0; i < 4; i++)
            begin
                cx_reg[i] <= in_data[18 + 36 * i +: 18];
                cy_reg[i] <= in_data[36 + 36 * i +: 18];
            end
        end
    end

    // Sample index: restart on first sample, wrap at MAX_SAMPLES
    assign idx_sel = (func_t'(in_func) == FUNC_FIRST) ? '0 : next_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_index_reg <= '0;
            idx_reg        <= '0;
        end
        else if (cmd.capture && (func_t'(in_func) inside {FUNC_NEXT, FUNC_FIRST}))
        begin
            idx_reg <= idx_sel;
            if (idx_sel == SIDXW'(MAX_SAMPLES - 1))
                next_index_reg <= '0;
            else
                next_index_reg <= idx_sel + SIDXW'(1);
        end
    end

    // Box bounds from the four corners
    logic signed [17:0] lx01, lx23, hx01, hx23, ly01, ly23, hy01, hy23;
    logic [LIMW-1:0]    limit;
    logic               do_wr;

    always_comb
    begin
        lx01        = (cx_reg[0] < cx_reg[1]) ? cx_reg[0] : cx_reg[1];
        lx23        = (cx_reg[2] < cx_reg[3]) ? cx_reg[2] : cx_reg[3];
        hx01        = (cx_reg[0] > cx_reg[1]) ? cx_reg[0] : cx_reg[1];
        hx23        = (cx_reg[2] > cx_reg[3]) ? cx_reg[2] : cx_reg[3];
        ly01        = (cy_reg[0] < cy_reg[1]) ? cy_reg[0] : cy_reg[1];
        ly23        = (cy_reg[2] < cy_reg[3]) ? cy_reg[2] : cy_reg[3];
        hy01        = (cy_reg[0] > cy_reg[1]) ? cy_reg[0] : cy_reg[1];
        hy23        = (cy_reg[2] > cy_reg[3]) ? cy_reg[2] : cy_reg[3];
        wr_box.lo_x = (lx01 < lx23) ? lx01 : lx23;
        wr_box.hi_x = (hx01 > hx23) ? hx01 : hx23;
        wr_box.lo_y = (ly01 < ly23) ? ly01 : ly23;
        wr_box.hi_y = (hy01 > hy23) ? hy01 : hy23;
        limit       = (LIMW'(max_boxes_reg) < LIMW'(MAX_BOXES)) ?
                      LIMW'(max_boxes_reg) : LIMW'(MAX_BOXES);
        box_base    = (func_reg == FUNC_NEW_SET) ? '0 : box_count_reg;
        do_wr       = cmd.box_wr && (LIMW'(box_base) < limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_count_reg <= '0;
        else if (cmd.box_wr)
            box_count_reg <= do_wr ? box_base + CNTW'(1) : box_base;
    end

    // Box store
    assign rd_issue = cmd.scan_step && (rd_idx_reg < box_count_reg);

    always_ff @(posedge clk)
    begin
        if (do_wr)
            box_mem[box_base[IDXW-1:0]] <= wr_box;
        if (rd_issue)
            rd_data_reg <= box_mem[rd_idx_reg[IDXW-1:0]];
    end

    // Trig value and sign per axis from the quadrant
    logic [30:0] xm, ym;
    logic        xneg, yneg;

    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                xm = p_reg; xneg = 1'b0;      ym = s_reg; yneg = tneg_reg;
            end
            2'd1:
            begin
                xm = s_reg; xneg = !tneg_reg; ym = p_reg; yneg = 1'b0;
            end
            2'd2:
            begin
                xm = p_reg; xneg = 1'b1;      ym = s_reg; yneg = !tneg_reg;
            end
            default:
            begin
                xm = s_reg; xneg = tneg_reg;  ym = p_reg; yneg = 1'b1;
            end
        endcase
    end

    // Shared multiplier operand selection
    always_comb
    begin
        case (cmd.uop.kind)
            UOP_ANGLE: begin op_a = 32'(idx_reg);   op_b = 32'(angle_step_reg);    end
            UOP_RAD:   begin op_a = 32'(u_reg);     op_b = TWO_PI_Q29;             end
            UOP_SQ:    begin op_a = 32'(x_reg);     op_b = 32'(x_reg);             end
            UOP_DIVM:  begin op_a = 32'(n_reg);     op_b = div_recip(cmd.uop.dsel); end
            UOP_DIVC:  begin op_a = 32'(q_reg);     op_b = 32'(div_value(cmd.uop.dsel)); end
            UOP_MULP:  begin op_a = 32'(x2_reg);    op_b = 32'(p_reg);             end
            UOP_SIN:   begin op_a = 32'(x_reg);     op_b = 32'(p_reg);             end
            UOP_SCX:   begin op_a = 32'(range_reg); op_b = 32'(xm);                end
            UOP_SCY:   begin op_a = 32'(range_reg); op_b = 32'(ym);                end
            default:   begin op_a = '0;             op_b = '0;                     end
        endcase
    end

    // Writeback terms
    logic [15:0]        ang_b;
    logic [13:0]        ang_d;
    logic [63:0]        sum_rad, sum_q30;
    logic [30:0]        rem, q_inc;
    logic [29:0]        q_fix;
    logic signed [17:0] v_s;

    always_comb
    begin
        ang_b   = angle_start_reg + prod_reg[15:0] + 16'd8192;
        ang_d   = ang_b[13:0];
        sum_rad = prod_reg + 64'd16384;
        sum_q30 = prod_reg + 64'h2000_0000;
        rem     = 31'(n_reg) - prod_reg[30:0];
        q_fix   = (rem >= 31'(div_value(cmd.uop.dsel))) ? q_reg + 30'd1 : q_reg;
        q_inc   = Q30_ONE - 31'(q_fix);
        v_s     = signed'({1'b0, sum_q30[46:30]});
    end

    // Multiply into prod_reg, then writeback from prod_reg, for each micro-op
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= op_a * op_b;
        if (cmd.wb_en)
        begin
            case (cmd.uop.kind)
                UOP_ANGLE:
                begin
                    k_reg    <= ang_b[15:14];
                    tneg_reg <= !ang_d[13];
                    u_reg    <= ang_d[13] ? ang_d - 14'd8192 : 14'd8192 - ang_d;
                end
                UOP_RAD:  x_reg <= sum_rad[44:15];
                UOP_SQ:
                begin
                    x2_reg <= sum_q30[59:30];
                    n_reg  <= sum_q30[59:30];
                end
                UOP_DIVM: q_reg <= prod_reg[61:32];
                UOP_DIVC: p_reg <= q_inc;
                UOP_MULP: n_reg <= prod_reg[59:30];
                UOP_SIN:
                begin
                    s_reg <= {1'b0, prod_reg[59:30]};
                    n_reg <= x2_reg;
                end
                UOP_SCX:  px_reg <= xneg ? -v_s : v_s;
                UOP_SCY:  py_reg <= yneg ? -v_s : v_s;
                default:  ;
            endcase
        end
    end

    // Box walk: one read issued and one compare per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            rd_vld_reg <= rd_issue;
            if (rd_issue)
                rd_idx_reg <= rd_idx_reg + CNTW'(1);
            if (rd_vld_reg &&
                px_reg >= rd_data_reg.lo_x && px_reg <= rd_data_reg.hi_x &&
                py_reg >= rd_data_reg.lo_y && py_reg <= rd_data_reg.hi_y)
                hit_reg <= 1'b1;
        end
    end

    assign status.scan_done = !rd_vld_reg && !(rd_idx_reg < box_count_reg);
    assign status.out_free  = !out_vld_reg || out_ready;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.out_load)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= {1'b0, 12'(idx_reg), hit_reg & !inval_reg, inval_reg, range_reg};
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/scan_point_box_mask_top.sv @@
`default_nettype none

// Range-sample box mask. Box transactions (tuser 2 starts a new set, 3 appends) store the
// min/max x and y of four corners, up to min(max_boxes, MAX_BOXES) boxes. Sample transactions
// (tuser 0 next, 1 first of scan) take the angle angle_start + index*angle_step, form sine
// and cosine by Taylor series in Q30 on one shared 32x32 multiplier (28 micro-ops), scale
// the range to x and y, then walk the stored boxes one per cycle; the time per sample is set
// by the multiplier sequence and the single read port of the box store. One result is
// produced per sample and none per box; the output register lets the next transaction be
// accepted while a result waits. Configuration writes belong to idle periods.
// Units: 1/1024 m, angles 2^-16 turn.
module scan_point_box_mask_top
    import spbm_pkg::*;
#(
    parameter int MAX_BOXES   = 32,
    parameter int MAX_SAMPLES = 4096
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // range_value[16:0], range_invalid, corner0_x, corner0_y .. corner3_x, corner3_y, pad
    input  wire logic [167:0] s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // range_out[16:0], range_invalid_out, masked, sample_index[11:0], pad
    output logic [31:0]       m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    spbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spbm_dp #(
        .MAX_BOXES   (MAX_BOXES),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_func   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
module tb_top;
    import spbm_pkg::*;

    localparam int  STORE_DEPTH = 32;
    localparam int  INDEX_WRAP  = 4096;
    localparam int  SETTLE      = 300;
    localparam int  CYCLE_LIMIT = 4000000;

    typedef struct {
        func_t        func;
        logic [167:0] data;
    } scan_item_t;

    typedef struct {
        logic [16:0] range_out;
        logic        invalid_out;
        logic        masked;
        logic [11:0] index;
    } mask_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    scan_item_t   pending_items[$];
    mask_result_t expected_results[$];
    int           fail_count;
    int           cycle_count;
    bit           calm;

    // Shadow state of the block
    longint       shadow_lx[STORE_DEPTH];
    longint       shadow_hx[STORE_DEPTH];
    longint       shadow_ly[STORE_DEPTH];
    longint       shadow_hy[STORE_DEPTH];
    int           shadow_count;
    int           shadow_index;
    logic [15:0]  shadow_start;
    logic [15:0]  shadow_step;
    logic [5:0]   shadow_limit;

    scan_point_box_mask_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // sin and cos magnitudes in Q30 for a residue angle of 0..8192
    function automatic void taylor_q30(input longint unsigned u, output longint unsigned s,
                                       output longint unsigned c);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned one;
        one = 64'd1 << 30;
        x  = (u * 64'd3373259426 + (64'd1 << 14)) >> 15;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        p = one - x2 / 72;
        p = one - ((x2 * p) >> 30) / 42;
        p = one - ((x2 * p) >> 30) / 20;
        p = one - ((x2 * p) >> 30) / 6;
        s = (x * p) >> 30;
        p = one - x2 / 56;
        p = one - ((x2 * p) >> 30) / 30;
        p = one - ((x2 * p) >> 30) / 12;
        p = one - ((x2 * p) >> 30) / 2;
        c = p;
    endfunction

    function automatic longint scale_coord(input longint unsigned r, input longint unsigned m,
                                           input bit neg);
        longint v;
        v = longint'((r * m + (64'd1 << 29)) >> 30);
        return neg ? -v : v;
    endfunction

    // Box min/max from the four corners
    task automatic store_box(input logic [167:0] d);
        longint xs[4];
        longint ys[4];
        int     limit;
        limit = (shadow_limit < STORE_DEPTH) ? shadow_limit : STORE_DEPTH;
        if (shadow_count >= limit)
            return;
        for (int i = 0; i < 4; i++)
        begin
            xs[i] = longint'($signed(d[18 + 36 * i +: 18]));
            ys[i] = longint'($signed(d[36 + 36 * i +: 18]));
        end
        shadow_lx[shadow_count] = xs[0];
        shadow_hx[shadow_count] = xs[0];
        shadow_ly[shadow_count] = ys[0];
        shadow_hy[shadow_count] = ys[0];
        for (int i = 1; i < 4; i++)
        begin
            if (xs[i] < shadow_lx[shadow_count]) shadow_lx[shadow_count] = xs[i];
            if (xs[i] > shadow_hx[shadow_count]) shadow_hx[shadow_count] = xs[i];
            if (ys[i] < shadow_ly[shadow_count]) shadow_ly[shadow_count] = ys[i];
            if (ys[i] > shadow_hy[shadow_count]) shadow_hy[shadow_count] = ys[i];
        end
        shadow_count++;
    endtask

    // Expected outcome of one accepted transaction
    task automatic predict_mask(input scan_item_t it);
        int              idx;
        int unsigned     a;
        int unsigned     k;
        int unsigned     d;
        int unsigned     u;
        bit              tneg;
        bit              xneg;
        bit              yneg;
        longint unsigned s;
        longint unsigned c;
        longint unsigned xm;
        longint unsigned ym;
        longint unsigned r;
        longint          px;
        longint          py;
        mask_result_t    res;
        if (it.func == FUNC_NEW_SET)
        begin
            shadow_count = 0;
            store_box(it.data);
            return;
        end
        if (it.func == FUNC_APPEND)
        begin
            store_box(it.data);
            return;
        end
        idx = (it.func == FUNC_FIRST) ? 0 : shadow_index;
        shadow_index = (idx + 1) % INDEX_WRAP;
        a = (shadow_start + idx * shadow_step) & 32'hFFFF;
        k = ((a + 8192) >> 14) & 3;
        d = (a + 8192 - k * 16384) & 32'hFFFF;
        tneg = d < 8192;
        u = tneg ? 8192 - d : d - 8192;
        taylor_q30(u, s, c);
        case (k)
            0:       begin xm = c; xneg = 1'b0;  ym = s; yneg = tneg;  end
            1:       begin xm = s; xneg = !tneg; ym = c; yneg = 1'b0;  end
            2:       begin xm = c; xneg = 1'b1;  ym = s; yneg = !tneg; end
            default: begin xm = s; xneg = tneg;  ym = c; yneg = 1'b1;  end
        endcase
        r  = it.data[16:0];
        px = scale_coord(r, xm, xneg);
        py = scale_coord(r, ym, yneg);
        res.range_out   = it.data[16:0];
        res.invalid_out = it.data[17];
        res.masked      = 1'b0;
        res.index       = idx[11:0];
        if (!it.data[17])
        begin
            for (int i = 0; i < shadow_count; i++)
            begin
                if (px >= shadow_lx[i] && px <= shadow_hx[i] &&
                    py >= shadow_ly[i] && py <= shadow_hy[i])
                    res.masked = 1'b1;
            end
        end
        expected_results = {expected_results, res};
    endtask

    // Input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_mask(scan_item_t'{func_t'(s_axis_tuser), s_axis_tdata});
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 27))
                begin
                    scan_item_t nxt;
                    nxt = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.func;
                    s_axis_tdata  <= nxt.data;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected transaction, actual %h", $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    mask_result_t e;
                    e = expected_results.pop_front();
                    if (m_axis_tdata[16:0] !== e.range_out)
                    begin
                        $display("%0t: range_out expected %0d actual %0d", $time,
                                 e.range_out, m_axis_tdata[16:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[17] !== e.invalid_out)
                    begin
                        $display("%0t: range_invalid_out expected %0d actual %0d", $time,
                                 e.invalid_out, m_axis_tdata[17]);
                        fail_count++;
                    end
                    if (m_axis_tdata[18] !== e.masked)
                    begin
                        $display("%0t: masked expected %0d actual %0d", $time,
                                 e.masked, m_axis_tdata[18]);
                        fail_count++;
                    end
                    if (m_axis_tdata[30:19] !== e.index)
                    begin
                        $display("%0t: sample_index expected %0d actual %0d", $time,
                                 e.index, m_axis_tdata[30:19]);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 27);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_sample(input func_t f, input int r, input bit inv);
        scan_item_t it;
        it.func = f;
        it.data = '0;
        it.data[16:0] = r[16:0];
        it.data[17] = inv;
        pending_items = {pending_items, it};
    endtask

    task automatic push_box(input func_t f, input int cx[4], input int cy[4]);
        scan_item_t it;
        it.func = f;
        it.data = '0;
        for (int i = 0; i < 4; i++)
        begin
            it.data[18 + 36 * i +: 18] = cx[i][17:0];
            it.data[36 + 36 * i +: 18] = cy[i][17:0];
        end
        pending_items = {pending_items, it};
    endtask

    // Rectangle with its corners rotated by a random offset, or four arbitrary points
    task automatic push_random_box(input func_t f);
        int cx[4];
        int cy[4];
        int mx;
        int my;
        int hw;
        int hh;
        int rot;
        if ($urandom_range(9) == 0)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cx[i] = $urandom;
                cy[i] = $urandom;
            end
        end
        else
        begin
            mx  = int'($urandom_range(200000)) - 100000;
            my  = int'($urandom_range(200000)) - 100000;
            hw  = $urandom_range(25000);
            hh  = $urandom_range(25000);
            rot = $urandom_range(3);
            for (int i = 0; i < 4; i++)
            begin
                cx[(i + rot) % 4] = (i == 0 || i == 3) ? mx - hw : mx + hw;
                cy[(i + rot) % 4] = (i < 2) ? my - hh : my + hh;
            end
        end
        push_box(f, cx, cy);
    endtask

    task automatic push_random_sample(input func_t f);
        int r;
        r = ($urandom_range(3) == 0) ? $urandom : $urandom_range(80000);
        push_sample(f, r, $urandom_range(7) == 0);
    endtask

    // One box set followed by one scan
    task automatic push_scan(input int boxes, input int samples);
        push_random_box(FUNC_NEW_SET);
        for (int i = 1; i < boxes; i++)
            push_random_box(FUNC_APPEND);
        push_random_sample(FUNC_FIRST);
        for (int i = 1; i < samples; i++)
            push_random_sample(FUNC_NEXT);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ANGLE_START: shadow_start = val;
            CFG_ANGLE_STEP:  shadow_step  = val;
            default:         shadow_limit = val[5:0];
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int cx[4];
        int cy[4];
        int p_start[7];
        int p_step[7];
        int p_limit[7];
        int issued;
        p_start = '{16'h8000, 16'h7FFF, 16'h0000, 16'h1234, 16'hC000, 16'h0F00, 16'h4000};
        p_step  = '{16'h0000, 16'hFFFF, 16'h0100, 16'h0B6D, 16'h0007, 16'h2000, 16'h0040};
        p_limit = '{0, 32, 63, 1, 20, 5, 33};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        fail_count    = 0;
        cycle_count   = 0;
        calm          = 1'b0;
        shadow_count  = 0;
        shadow_index  = 0;
        shadow_start  = '0;
        shadow_step   = '0;
        shadow_limit  = MAX_BOXES_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset configuration, angle 0 so x = range, y = 0
        push_sample(FUNC_FIRST, 0, 1'b0);
        push_sample(FUNC_NEXT, 131071, 1'b0);
        cx = '{-131072, 131071, 0, -1};
        cy = '{-131072, 131071, 0, 1};
        push_box(FUNC_NEW_SET, cx, cy);
        push_sample(FUNC_FIRST, 1000, 1'b0);
        push_sample(FUNC_NEXT, 131071, 1'b1);
        cx = '{131071, -131072, 131071, -131072};
        cy = '{131071, 131071, -131072, -131072};
        push_box(FUNC_APPEND, cx, cy);
        push_sample(FUNC_NEXT, 131071, 1'b0);
        cx = '{6000, 5000, 5000, 6000};
        cy = '{-100, 100, -100, 100};
        push_box(FUNC_NEW_SET, cx, cy);
        push_sample(FUNC_FIRST, 5000, 1'b0);
        push_sample(FUNC_NEXT, 6000, 1'b0);
        push_sample(FUNC_NEXT, 6001, 1'b0);
        push_sample(FUNC_NEXT, 4999, 1'b0);
        push_sample(FUNC_NEXT, 5500, 1'b1);
        drain();

        // Limit zero: a new set stays empty
        write_cfg(CFG_MAX_BOXES, 16'd0);
        push_box(FUNC_NEW_SET, cx, cy);
        push_sample(FUNC_FIRST, 5500, 1'b0);
        drain();

        // Randomized phases over several angle and limit settings
        for (int ph = 0; ph < 7; ph++)
        begin
            write_cfg(CFG_ANGLE_START, p_start[ph][15:0]);
            write_cfg(CFG_ANGLE_STEP, p_step[ph][15:0]);
            write_cfg(CFG_MAX_BOXES, p_limit[ph][15:0]);
            calm = (ph == 3);
            issued = 0;
            while (issued < 105)
            begin
                int nb;
                int ns;
                nb = (ph == 1 || ph == 6) ? $urandom_range(36) : $urandom_range(1, 8);
                ns = $urandom_range(4, 20);
                if ($urandom_range(9) == 0)
                begin
                    // noise: loose transactions of any kind
                    for (int i = 0; i < 4; i++)
                    begin
                        if ($urandom_range(1)) push_random_box(func_t'($urandom_range(2, 3)));
                        else push_random_sample(func_t'($urandom_range(1)));
                    end
                    issued += 4;
                end
                else
                begin
                    push_scan(nb == 0 ? 1 : nb, ns);
                    issued += ns + 1;
                end
            end
            drain();
        end
        calm = 1'b0;

        // Longer scan with an empty box set
        write_cfg(CFG_MAX_BOXES, 16'd0);
        write_cfg(CFG_ANGLE_STEP, 16'd17);
        push_random_box(FUNC_NEW_SET);
        push_random_sample(FUNC_FIRST);
        for (int i = 0; i < 60; i++)
            push_random_sample(FUNC_NEXT);
        drain();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/spbm_pkg.sv
hw/rtl/spbm_ctrl.sv
hw/rtl/spbm_dp.sv
hw/rtl/scan_point_box_mask_top.sv
verif/tb_top.sv
